@@ rtl/rmct_pkg.sv @@
package rmct_pkg;

  // Sample width and per-node counter width.
  localparam int VALUE_BITS = 10;
  localparam int COUNT_BITS = 16;

  // Heap-ordered tree: root at 1, leaves at 2^VALUE_BITS + offset value.
  localparam int NODE_BITS  = VALUE_BITS + 1;
  localparam int TREE_SIZE  = 2 ** NODE_BITS;
  localparam int LEVEL_BITS = $clog2(VALUE_BITS + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;
    logic accept;
    logic ins_step;
    logic sel_init_hi;
    logic sel_init_lo;
    logic sel_read;
    logic sel_step;
    logic cap_a;
    logic cap_b;
    logic load_out;
  } rmct_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic clr_last;
    logic full;
    logic ins_done;
    logic sel_done;
    logic n_odd;
    logic out_free;
  } rmct_status_t;

endpackage

@@ rtl/rmct_dpath.sv @@
module rmct_dpath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  rmct_pkg::rmct_cmd_t                    cmd,
  output rmct_pkg::rmct_status_t                 status,
  input  logic signed [rmct_pkg::VALUE_BITS-1:0] sample,
  input  logic                                   result_stall,
  output logic                                   result_valid,
  output logic signed [rmct_pkg::VALUE_BITS:0]   median_doubled,
  output logic [rmct_pkg::COUNT_BITS-1:0]        sample_count,
  output logic                                   saturated
);
  import rmct_pkg::*;

  logic [COUNT_BITS-1:0] mem [TREE_SIZE];
  logic [COUNT_BITS-1:0] rd_data;
  logic [COUNT_BITS-1:0] wr_data;
  logic [COUNT_BITS-1:0] total;
  logic [COUNT_BITS-1:0] rank;
  logic [NODE_BITS-1:0]  node;
  logic [NODE_BITS-1:0]  prev_node;
  logic [NODE_BITS-1:0]  clr_addr;
  logic [NODE_BITS-1:0]  rd_addr;
  logic [NODE_BITS-1:0]  wr_addr;
  logic [NODE_BITS-1:0]  sum;
  logic [LEVEL_BITS-1:0] level;
  logic [VALUE_BITS-1:0] a_val;
  logic [VALUE_BITS-1:0] b_val;
  logic [VALUE_BITS-1:0] u;
  logic                  pend;
  logic                  sat;
  logic                  wr_en;
  logic                  rd_en;

  // Offset value: flipping the sign bit maps the signed range onto 0 .. 2^VALUE_BITS-1.
  assign u = {~sample[VALUE_BITS-1], sample[VALUE_BITS-2:0]};

  // Sum of the two middle values, with the doubled offset removed modulo 2^NODE_BITS.
  assign sum = {1'b0, a_val} + {1'b0, b_val} + {1'b1, {VALUE_BITS{1'b0}}};

  always_comb begin
    wr_en   = cmd.clr | (cmd.ins_step & pend);
    wr_addr = cmd.clr ? clr_addr : prev_node;
    wr_data = cmd.clr ? '0 : rd_data + 1'b1;
    rd_en   = cmd.sel_read | (cmd.ins_step & (node != '0));
    rd_addr = cmd.sel_read ? {node[VALUE_BITS-1:0], 1'b0} : node;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr     <= '0;
      total        <= '0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.accept && !status.full) begin
        total <= total + 1'b1;
      end
      if (cmd.accept) begin
        pend <= 1'b0;
      end else if (cmd.ins_step) begin
        pend <= (node != '0);
      end
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.accept) begin
      sat  <= status.full;
      node <= status.full ? '0 : {1'b1, u};
    end else if (cmd.ins_step) begin
      prev_node <= node;
      node      <= node >> 1;
    end else if (cmd.sel_init_hi || cmd.sel_init_lo) begin
      node  <= NODE_BITS'(1);
      level <= '0;
      rank  <= cmd.sel_init_hi ? (total >> 1) + 1'b1 : total >> 1;
    end else if (cmd.sel_step) begin
      level <= level + 1'b1;
      if (rd_data >= rank) begin
        node <= {node[VALUE_BITS-1:0], 1'b0};
      end else begin
        rank <= rank - rd_data;
        node <= {node[VALUE_BITS-1:0], 1'b1};
      end
    end else begin
      node <= node;
    end
    if (cmd.cap_a) begin
      a_val <= node[VALUE_BITS-1:0];
      b_val <= node[VALUE_BITS-1:0];
    end
    if (cmd.cap_b) begin
      b_val <= node[VALUE_BITS-1:0];
    end
    if (cmd.load_out) begin
      median_doubled <= signed'(sum);
      sample_count   <= total;
      saturated      <= sat;
    end
  end

  always_comb begin
    status.clr_last = &clr_addr;
    status.full     = (total == COUNT_MAX);
    status.ins_done = (node == '0) && !pend;
    status.sel_done = (level == LEVEL_BITS'(VALUE_BITS));
    status.n_odd    = total[0];
    status.out_free = !result_valid || !result_stall;
  end

endmodule

@@ rtl/rmct_ctrl.sv @@
module rmct_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  rmct_pkg::rmct_status_t status,
  output rmct_pkg::rmct_cmd_t    cmd
);
  import rmct_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INS,
    S_LOOK,
    S_STEP,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   second;
  logic   second_next;

  always_comb begin
    cmd         = '0;
    state_next  = state;
    second_next = second;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (sample_valid) begin
          cmd.accept = 1'b1;
          state_next = S_INS;
        end
      end
      S_INS: begin
        if (status.ins_done) begin
          cmd.sel_init_hi = 1'b1;
          second_next     = 1'b0;
          state_next      = S_LOOK;
        end else begin
          cmd.ins_step = 1'b1;
        end
      end
      S_LOOK: begin
        if (!status.sel_done) begin
          cmd.sel_read = 1'b1;
          state_next   = S_STEP;
        end else if (!second) begin
          cmd.cap_a = 1'b1;
          if (status.n_odd) begin
            state_next = S_DONE;
          end else begin
            cmd.sel_init_lo = 1'b1;
            second_next     = 1'b1;
          end
        end else begin
          cmd.cap_b  = 1'b1;
          state_next = S_DONE;
        end
      end
      S_STEP: begin
        cmd.sel_step = 1'b1;
        state_next   = S_LOOK;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign sample_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
    end
  end

endmodule

@@ rtl/running_median_counting_tree_unit.sv @@
// An item with an odd count takes one rank descent and one with an even count two; a dropped
// item is not inserted and takes one descent. A finished result waits while the previous
// result still holds the output register. One item at a time: the next is taken at the
// earliest in the cycle the current result is first offered. Insert reads and increments each
// node from leaf to root, and each rank descent a read and a decide step per level. Reset (rst,
// synchronous) clears the total and result valid; a clear pass then zeroes every memory entry.
module running_median_counting_tree_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   sample_valid,
  output logic                                   sample_stall,
  input  logic signed [rmct_pkg::VALUE_BITS-1:0] sample,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic signed [rmct_pkg::VALUE_BITS:0]   median_doubled,
  output logic [rmct_pkg::COUNT_BITS-1:0]        sample_count,
  output logic                                   saturated
);
  import rmct_pkg::*;

  // The controller sequences one item at a time: it inserts the sample by walking from its
  // leaf up to the root, then descends from the root once for an odd count, or twice for an
  // even count, to find the middle value or values by rank.
  rmct_cmd_t    cmd;
  rmct_status_t status;

  rmct_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // The datapath holds the count memory, the rank and node registers, and the output
  // register, which lets the next item enter while a finished result waits to be taken.
  rmct_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .sample         (sample),
    .result_stall   (result_stall),
    .result_valid   (result_valid),
    .median_doubled (median_doubled),
    .sample_count   (sample_count),
    .saturated      (saturated)
  );

  // A dropped item is only ever reported with the count at its maximum.
  a_sat_full: assert property (@(posedge clk) disable iff (rst)
    result_valid && saturated |-> sample_count == COUNT_MAX)
    else $error("saturated item reported below the maximum count");

  // Every reported result follows at least one inserted sample.
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> sample_count != '0)
    else $error("result reported with an empty sample set");

  // With an odd count the result is twice one value, so it is even.
  a_odd_even: assert property (@(posedge clk) disable iff (rst)
    result_valid && sample_count[0] |-> !median_doubled[0])
    else $error("odd count gave an odd doubled median");

  // After taking an item the block is busy with it.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("item accepted in back-to-back cycles");

endmodule
